// ----- rtl/core/virtio_mmio_block_transport_regs_top_macros.svh -----
// Assertion helpers for the RTL of the transport register block.
`ifndef VIRTIO_MMIO_BLOCK_TRANSPORT_REGS_TOP_MACROS_SVH
`define VIRTIO_MMIO_BLOCK_TRANSPORT_REGS_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VMBT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define VMBT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/vmbt_pkg.sv -----
package vmbt_pkg;

  // Access kinds carried in the func field.
  localparam logic [2:0] FUNC_WORD_READ  = 3'd0;
  localparam logic [2:0] FUNC_WORD_WRITE = 3'd1;
  localparam logic [2:0] FUNC_BYTE_READ  = 3'd2;
  localparam logic [2:0] FUNC_IGNORED    = 3'd3;
  localparam logic [2:0] FUNC_COMPLETION = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd1;

  localparam logic [63:0] WINDOW_BASE_RESET = 64'h0000_0000_D000_0000;
  localparam int unsigned CAPACITY_W = 48;

  // Transport register offsets.
  localparam logic [11:0] REG_MAGIC            = 12'h000;
  localparam logic [11:0] REG_VERSION          = 12'h004;
  localparam logic [11:0] REG_DEVICE_ID        = 12'h008;
  localparam logic [11:0] REG_VENDOR_ID        = 12'h00c;
  localparam logic [11:0] REG_DEV_FEATURES     = 12'h010;
  localparam logic [11:0] REG_DEV_FEATURES_SEL = 12'h014;
  localparam logic [11:0] REG_QUEUE_NUM_MAX    = 12'h034;
  localparam logic [11:0] REG_QUEUE_NUM        = 12'h038;
  localparam logic [11:0] REG_QUEUE_READY      = 12'h044;
  localparam logic [11:0] REG_QUEUE_NOTIFY     = 12'h050;
  localparam logic [11:0] REG_IRQ_STATUS       = 12'h060;
  localparam logic [11:0] REG_IRQ_ACK          = 12'h064;
  localparam logic [11:0] REG_STATUS           = 12'h070;
  localparam logic [11:0] REG_DESC_LO          = 12'h080;
  localparam logic [11:0] REG_DESC_HI          = 12'h084;
  localparam logic [11:0] REG_AVAIL_LO         = 12'h090;
  localparam logic [11:0] REG_AVAIL_HI         = 12'h094;
  localparam logic [11:0] REG_USED_LO          = 12'h0a0;
  localparam logic [11:0] REG_USED_HI          = 12'h0a4;
  localparam logic [11:0] REG_CONFIG_BASE      = 12'h100;

  // Fixed register contents.
  localparam logic [31:0] MAGIC_VALUE     = 32'h7472_6976;
  localparam logic [31:0] VERSION_VALUE   = 32'd2;
  localparam logic [31:0] DEVICE_ID_VALUE = 32'd2;
  localparam logic [31:0] VENDOR_VALUE    = 32'h554d_4551;
  localparam logic [31:0] DEV_FEATURES_LO = 32'h0000_0006;
  localparam logic [31:0] DEV_FEATURES_HI = 32'h0000_0001;

  // Block config space layout.
  localparam int unsigned CFG_BYTES = 24;
  localparam int unsigned CFG_BYTE_IDX_W = 5;
  localparam logic [31:0] SIZE_MAX_VALUE = 32'd65536;
  localparam logic [31:0] SEG_MAX_VALUE  = 32'd128;
  localparam logic [31:0] GEOMETRY_VALUE = 32'd0;
  localparam logic [31:0] BLK_SIZE_VALUE = 32'd512;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] bus_addr;
    logic [31:0] write_data;
  } vmbt_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_data;
    logic        notify_pulse;
  } vmbt_resp_t;

  typedef struct packed {
    logic        irq_pending;
    logic [8:0]  queue_size;
    logic [63:0] desc_ring_addr;
    logic [63:0] avail_ring_addr;
    logic [63:0] used_ring_addr;
  } vmbt_state_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;
  } vmbt_cfg_wr_t;

endpackage

// ----- rtl/core/vmbt_if.sv -----
interface vmbt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [63:0] bus_addr;
  logic [31:0] write_data;

  modport source (output valid, func, bus_addr, write_data, input ready);
  modport sink (input valid, func, bus_addr, write_data, output ready);
endinterface

interface vmbt_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] read_data;
  logic        notify_pulse;
  logic        irq_pending;
  logic [8:0]  queue_size;
  logic [63:0] desc_ring_addr;
  logic [63:0] avail_ring_addr;
  logic [63:0] used_ring_addr;

  modport source (output valid, hit, read_data, notify_pulse, irq_pending, queue_size,
                  desc_ring_addr, avail_ring_addr, used_ring_addr, input ready);
  modport sink (input valid, hit, read_data, notify_pulse, irq_pending, queue_size,
                desc_ring_addr, avail_ring_addr, used_ring_addr, output ready);
endinterface

interface vmbt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/vmbt_regs.sv -----
module vmbt_regs
  import vmbt_pkg::*;
#(
  parameter int unsigned QUEUE_MAX    = 256,
  parameter int unsigned WINDOW_BYTES = 512
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  vmbt_cfg_wr_t cfg_i,
  input  logic         step_i,
  input  vmbt_item_t   item_i,
  output vmbt_resp_t   resp_o,
  output vmbt_state_t  state_o
);

  localparam int unsigned OffW = $clog2(WINDOW_BYTES);
  localparam int unsigned QcW  = $clog2(QUEUE_MAX + 1);
  localparam logic [31:0] QueueMaxW = 32'(QUEUE_MAX);
  localparam int unsigned CfgVecW = CFG_BYTES * 8;

  logic [63:0]           base_q;
  logic [CAPACITY_W-1:0] capacity_q;

  logic [31:0]    dev_sel_q, dev_sel_d;
  logic [QcW-1:0] queue_q, queue_d;
  logic [31:0]    ready_q, ready_d;
  logic [31:0]    irq_q, irq_d;
  logic [31:0]    status_q, status_d;
  logic [63:0]    desc_q, desc_d;
  logic [63:0]    avail_q, avail_d;
  logic [63:0]    used_q, used_d;

  logic [64:0]         diff;
  logic                in_window;
  logic [OffW-1:0]     off;
  logic [OffW-1:0]     cfg_off;
  logic                is_cfg;
  logic [CfgVecW-1:0]  cfg_vec;
  logic [31:0]         word_rdata;
  logic                ring_ok;
  logic [31:0]         qc_ext;

  function automatic logic [7:0] cfg_byte(input logic [CfgVecW-1:0] v,
                                          input logic [OffW-1:0] c);
    logic [7:0] b;
    b = '0;
    if (32'(c) < CFG_BYTES) begin
      b = v[{c[CFG_BYTE_IDX_W-1:0], 3'b000} +: 8];
    end
    return b;
  endfunction

  // Window test without wraparound: the borrow out of the subtraction marks
  // an address below the base.
  assign diff      = {1'b0, item_i.bus_addr} - {1'b0, base_q};
  assign off       = diff[OffW-1:0];
  assign in_window = !diff[64] && (diff[63:OffW] == '0) && (32'(off) < 32'(WINDOW_BYTES));
  assign is_cfg    = off >= OffW'(REG_CONFIG_BASE);
  assign cfg_off   = off - OffW'(REG_CONFIG_BASE);

  assign cfg_vec = {BLK_SIZE_VALUE, GEOMETRY_VALUE, SEG_MAX_VALUE, SIZE_MAX_VALUE,
                    16'h0000, capacity_q};

  assign ring_ok = (ready_q != '0) && (desc_q != '0) && (avail_q != '0) && (used_q != '0);

  always_comb begin
    word_rdata = '0;
    if (is_cfg) begin
      word_rdata = {cfg_byte(cfg_vec, cfg_off + OffW'(3)), cfg_byte(cfg_vec, cfg_off + OffW'(2)),
                    cfg_byte(cfg_vec, cfg_off + OffW'(1)), cfg_byte(cfg_vec, cfg_off)};
    end else begin
      unique case (off)
        OffW'(REG_MAGIC):         word_rdata = MAGIC_VALUE;
        OffW'(REG_VERSION):       word_rdata = VERSION_VALUE;
        OffW'(REG_DEVICE_ID):     word_rdata = DEVICE_ID_VALUE;
        OffW'(REG_VENDOR_ID):     word_rdata = VENDOR_VALUE;
        OffW'(REG_DEV_FEATURES): begin
          if (dev_sel_q == 32'd0) begin
            word_rdata = DEV_FEATURES_LO;
          end else if (dev_sel_q == 32'd1) begin
            word_rdata = DEV_FEATURES_HI;
          end
        end
        OffW'(REG_QUEUE_NUM_MAX): word_rdata = QueueMaxW;
        OffW'(REG_QUEUE_READY):   word_rdata = ready_q;
        OffW'(REG_IRQ_STATUS):    word_rdata = irq_q;
        OffW'(REG_STATUS):        word_rdata = status_q;
        default:                  word_rdata = '0;
      endcase
    end
  end

  always_comb begin
    resp_o.hit          = (item_i.func != FUNC_COMPLETION) && in_window;
    resp_o.read_data    = '0;
    resp_o.notify_pulse = 1'b0;
    if (resp_o.hit) begin
      if (item_i.func == FUNC_WORD_READ) begin
        resp_o.read_data = word_rdata;
      end else if (item_i.func == FUNC_BYTE_READ && is_cfg) begin
        resp_o.read_data = {24'h000000, cfg_byte(cfg_vec, cfg_off)};
      end else if (item_i.func == FUNC_WORD_WRITE && off == OffW'(REG_QUEUE_NOTIFY)) begin
        resp_o.notify_pulse = ring_ok;
      end
    end
  end

  always_comb begin
    dev_sel_d = dev_sel_q;
    queue_d   = queue_q;
    ready_d   = ready_q;
    irq_d     = irq_q;
    status_d  = status_q;
    desc_d    = desc_q;
    avail_d   = avail_q;
    used_d    = used_q;
    if (step_i) begin
      if (item_i.func == FUNC_COMPLETION) begin
        irq_d = irq_q | 32'd1;
      end else if (resp_o.hit && item_i.func == FUNC_WORD_WRITE) begin
        // Driver feature and queue select writes are accepted but nothing
        // in this block reads them back, so they hold no storage.
        unique case (off)
          OffW'(REG_DEV_FEATURES_SEL): dev_sel_d = item_i.write_data;
          OffW'(REG_QUEUE_NUM): begin
            if (item_i.write_data <= QueueMaxW) begin
              queue_d = QcW'(item_i.write_data);
            end
          end
          OffW'(REG_QUEUE_READY): ready_d  = item_i.write_data;
          OffW'(REG_IRQ_ACK):     irq_d    = irq_q & ~item_i.write_data;
          OffW'(REG_STATUS):      status_d = item_i.write_data;
          OffW'(REG_DESC_LO):     desc_d   = {desc_q[63:32], item_i.write_data};
          OffW'(REG_DESC_HI):     desc_d   = {item_i.write_data, desc_q[31:0]};
          OffW'(REG_AVAIL_LO):    avail_d  = {avail_q[63:32], item_i.write_data};
          OffW'(REG_AVAIL_HI):    avail_d  = {item_i.write_data, avail_q[31:0]};
          OffW'(REG_USED_LO):     used_d   = {used_q[63:32], item_i.write_data};
          OffW'(REG_USED_HI):     used_d   = {item_i.write_data, used_q[31:0]};
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= WINDOW_BASE_RESET;
      capacity_q <= '0;
      dev_sel_q  <= '0;
      queue_q    <= QcW'(QUEUE_MAX);
      ready_q    <= '0;
      irq_q      <= '0;
      status_q   <= '0;
      desc_q     <= '0;
      avail_q    <= '0;
      used_q     <= '0;
    end else begin
      if (cfg_i.en && cfg_i.index == CFG_WINDOW_BASE) begin
        base_q <= cfg_i.data;
      end
      if (cfg_i.en && cfg_i.index == CFG_CAPACITY) begin
        capacity_q <= cfg_i.data[CAPACITY_W-1:0];
      end
      dev_sel_q <= dev_sel_d;
      queue_q   <= queue_d;
      ready_q   <= ready_d;
      irq_q     <= irq_d;
      status_q  <= status_d;
      desc_q    <= desc_d;
      avail_q   <= avail_d;
      used_q    <= used_d;
    end
  end

  assign qc_ext = 32'(queue_q);

  // The state only moves when a result is loaded, so it always matches the
  // result that is currently held at the output.
  assign state_o.irq_pending     = irq_q != '0;
  assign state_o.queue_size      = qc_ext[8:0];
  assign state_o.desc_ring_addr  = desc_q;
  assign state_o.avail_ring_addr = avail_q;
  assign state_o.used_ring_addr  = used_q;

endmodule

// ----- rtl/core/virtio_mmio_block_transport_regs_top.sv -----
// Register block of a virtio-mmio block device transport.
// Channel in_i carries one item per bus access or completion event: func
// selects word read, word write, byte read, ignored access or completion.
// Channel out_o returns exactly one result item per input item, in order:
// window hit, read data, the notify pulse, and the interrupt, queue size and
// ring address state as left by that item.
// Channel cfg_i writes the window base (index 0) and the disk capacity in
// sectors (index 1); it is always ready. The user must write it only while
// the block is idle; the block does not enforce it. An item passes through
// one input register, the register decode and update, and one result register.
// Throughput is one item per cycle while out_o does not stall, set by that
// single decode stage; the state registers are read and written in the same
// cycle, so back-to-back accesses see each other's effect.
// When out_o stalls, the held result stays and one more item is taken into
// the input register; further items then wait with ready low.
// Reset puts the window at its default base, clears all transport state and
// sets the queue size to its maximum; no clearing pass is needed.
`include "virtio_mmio_block_transport_regs_top_macros.svh"

module virtio_mmio_block_transport_regs_top
  import vmbt_pkg::*;
#(
  parameter int unsigned QUEUE_MAX    = 256,
  parameter int unsigned WINDOW_BYTES = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vmbt_in_if.sink    in_i,
  vmbt_out_if.source out_o,
  vmbt_cfg_if.sink   cfg_i
);

  localparam logic [31:0] QueueMaxW = 32'(QUEUE_MAX);

  logic         s1_valid_q, s1_valid_d;
  vmbt_item_t   s1_q;
  logic         res_valid_q, res_valid_d;
  vmbt_resp_t   res_q;
  logic         s1_adv;
  logic         in_fire;
  vmbt_resp_t   resp;
  vmbt_state_t  state;
  vmbt_cfg_wr_t cfg_wr;

  assign s1_adv     = s1_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  assign cfg_i.ready  = 1'b1;
  assign cfg_wr.en    = cfg_i.valid;
  assign cfg_wr.index = cfg_i.index;
  assign cfg_wr.data  = cfg_i.data;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    res_valid_d = res_valid_q;
    if (s1_adv) begin
      res_valid_d = 1'b1;
    end else if (out_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.func       <= in_i.func;
      s1_q.bus_addr   <= in_i.bus_addr;
      s1_q.write_data <= in_i.write_data;
    end
    if (s1_adv) begin
      res_q <= resp;
    end
  end

  vmbt_regs #(
    .QUEUE_MAX    (QUEUE_MAX),
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_wr),
    .step_i  (s1_adv),
    .item_i  (s1_q),
    .resp_o  (resp),
    .state_o (state)
  );

  assign out_o.valid           = res_valid_q;
  assign out_o.hit             = res_q.hit;
  assign out_o.read_data       = res_q.read_data;
  assign out_o.notify_pulse    = res_q.notify_pulse;
  assign out_o.irq_pending     = state.irq_pending;
  assign out_o.queue_size      = state.queue_size;
  assign out_o.desc_ring_addr  = state.desc_ring_addr;
  assign out_o.avail_ring_addr = state.avail_ring_addr;
  assign out_o.used_ring_addr  = state.used_ring_addr;

  `VMBT_ASSERT_NXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s1_adv,
                   s1_valid_q && $stable(s1_q), "input register lost or changed an item")
  `VMBT_ASSERT_NXT(a_completion_irq, clk_i, rst_ni, s1_adv && s1_q.func == FUNC_COMPLETION,
                   out_o.valid && out_o.irq_pending && !out_o.hit,
                   "completion did not raise a pending interrupt")
  `VMBT_ASSERT_IMP(a_notify_hit, clk_i, rst_ni, out_o.valid && out_o.notify_pulse,
                   out_o.hit, "notify pulse without a window hit")
  `VMBT_ASSERT_IMP(a_rdata_hit, clk_i, rst_ni, out_o.valid && out_o.read_data != '0,
                   out_o.hit, "read data returned for a miss")
  `VMBT_ASSERT_IMP(a_queue_limit, clk_i, rst_ni, out_o.valid,
                   QueueMaxW > 32'd511 || 32'(out_o.queue_size) <= QueueMaxW,
                   "queue size above its limit")

endmodule
